/* hdl/rtc_pkg.sv */
`default_nettype none

package rtc_pkg;

	localparam int NUM_COMPARE_DEF = 4;
	localparam int COUNT_BITS_DEF = 24;
	localparam int MAX_COMPARE = 4;

	localparam int CMD_W = 4;
	localparam int IDX_W = 3;
	localparam int WDATA_W = 24;
	localparam int RDATA_W = 24;
	localparam int PRESCALER_W = 12;
	localparam int EVT_W = MAX_COMPARE + 1;
	localparam int OVF_IDX = MAX_COMPARE;
	localparam int OVF_LOAD_OFFSET = 15;

	localparam int S_DATA_W = 32;
	localparam int S_USER_W = CMD_W;
	localparam int M_DATA_W = 40;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK      = 4'd0,
		CMD_START     = 4'd1,
		CMD_STOP      = 4'd2,
		CMD_CLEAR     = 4'd3,
		CMD_TRIGOVF   = 4'd4,
		CMD_CAPTURE   = 4'd5,
		CMD_WRCC      = 4'd6,
		CMD_INTENSET  = 4'd7,
		CMD_INTENCLR  = 4'd8,
		CMD_EVTENSET  = 4'd9,
		CMD_EVTENCLR  = 4'd10,
		CMD_WREVENT   = 4'd11,
		CMD_RDCOUNT   = 4'd12,
		CMD_RDCC      = 4'd13
	} rtc_cmd_t;

	typedef enum logic [0:0] {
		REG_PRESCALER = 1'b0,
		REG_SHORT     = 1'b1
	} rtc_reg_t;

	typedef struct packed {
		logic [PRESCALER_W-1:0] prescaler;
		logic [MAX_COMPARE-1:0] compare_clear_short;
	} rtc_cfg_t;

	typedef struct packed {
		logic                   is_running;
		logic                   irq;
		logic                   overflow_pulse;
		logic [MAX_COMPARE-1:0] compare_pulse;
		logic                   overflow_event;
		logic [MAX_COMPARE-1:0] compare_events;
		logic [RDATA_W-1:0]     read_data;
	} rtc_result_t;

endpackage

`default_nettype wire

/* hdl/rtc_regs.sv */
`default_nettype none

module rtc_apb_cfg (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [rtc_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire  [rtc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [rtc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output rtc_pkg::rtc_cfg_t                 cfg
);
	import rtc_pkg::*;

	logic [PRESCALER_W-1:0] prescaler_q;
	logic [MAX_COMPARE-1:0] short_q;
	logic                   wr_en;
	rtc_reg_t               sel;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign sel = rtc_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescaler_q <= '0;
			short_q <= '0;
		end else if (wr_en) begin
			case (sel)
				REG_PRESCALER: prescaler_q <= pwdata[PRESCALER_W-1:0];
				REG_SHORT:     short_q <= pwdata[MAX_COMPARE-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_PRESCALER: prdata = APB_DATA_W'(prescaler_q);
			REG_SHORT:     prdata = APB_DATA_W'(short_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.prescaler = prescaler_q;
	assign cfg.compare_clear_short = short_q;

endmodule

`default_nettype wire

/* hdl/rtc_core.sv */
`default_nettype none

module rtc_core #(
	parameter int NUM_COMPARE = rtc_pkg::NUM_COMPARE_DEF,
	parameter int COUNT_BITS = rtc_pkg::COUNT_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  rtc_pkg::rtc_cfg_t              cfg,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [rtc_pkg::CMD_W-1:0]      in_cmd,
	input  wire  [rtc_pkg::IDX_W-1:0]      in_index,
	input  wire  [rtc_pkg::WDATA_W-1:0]    in_wdata,
	output logic                           res_valid,
	input  wire                            res_ready,
	output rtc_pkg::rtc_result_t           res
);
	import rtc_pkg::*;

	localparam logic [EVT_W-1:0] EnMask =
		{1'b1, MAX_COMPARE'((1 << NUM_COMPARE) - 1)};
	localparam logic [COUNT_BITS-1:0] OvfLoad =
		{COUNT_BITS{1'b1}} - COUNT_BITS'(OVF_LOAD_OFFSET);

	logic                  valid_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic [IDX_W-1:0]      index_s1;
	logic [WDATA_W-1:0]    wdata_s1;

	logic [COUNT_BITS-1:0]  count_q;
	logic [PRESCALER_W-1:0] phase_q;
	logic [PRESCALER_W-1:0] latched_q;
	logic                   running_q;
	logic [COUNT_BITS-1:0]  cc_q [NUM_COMPARE];
	logic [EVT_W-1:0]       int_en_q;
	logic [EVT_W-1:0]       evt_en_q;
	logic [EVT_W-1:0]       flags_q;

	logic [COUNT_BITS-1:0]  count_n;
	logic [PRESCALER_W-1:0] phase_n;
	logic [PRESCALER_W-1:0] latched_n;
	logic                   running_n;
	logic [COUNT_BITS-1:0]  cc_n [NUM_COMPARE];
	logic [EVT_W-1:0]       int_en_n;
	logic [EVT_W-1:0]       evt_en_n;
	logic [EVT_W-1:0]       flags_n;
	logic [EVT_W-1:0]       pulses;
	logic [RDATA_W-1:0]     rd;
	logic                   advance;

	assign advance = valid_s1 && res_ready;
	assign in_ready = !valid_s1 || res_ready;
	assign res_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= in_cmd;
			index_s1 <= in_index;
			wdata_s1 <= in_wdata;
		end
	end

	always_comb begin
		logic [COUNT_BITS-1:0]  inc;
		logic [NUM_COMPARE-1:0] matched;
		logic [EVT_W-1:0]       hit;
		logic [EVT_W-1:0]       evt_bit;

		count_n = count_q;
		phase_n = phase_q;
		latched_n = latched_q;
		running_n = running_q;
		cc_n = cc_q;
		int_en_n = int_en_q;
		evt_en_n = evt_en_q;
		flags_n = flags_q;
		pulses = '0;
		rd = '0;
		inc = count_q + COUNT_BITS'(1);
		matched = '0;
		evt_bit = '0;
		for (int i = 0; i < NUM_COMPARE; i++) begin
			matched[i] = (cc_q[i] == inc);
			evt_bit[i] = (index_s1 == IDX_W'(i));
		end
		evt_bit[OVF_IDX] = (index_s1 == IDX_W'(OVF_IDX));
		hit = {(inc == '0), MAX_COMPARE'(matched)};

		case (cmd_s1)
			CMD_TICK: begin
				if (running_q) begin
					if (phase_q >= latched_q) begin
						phase_n = '0;
						count_n = inc;
						flags_n = flags_q | (hit & (evt_en_q | int_en_q));
						pulses = hit & evt_en_q;
						if (|(matched & cfg.compare_clear_short[NUM_COMPARE-1:0])) begin
							count_n = '0;
							latched_n = cfg.prescaler;
						end
					end else begin
						phase_n = phase_q + PRESCALER_W'(1);
					end
				end
			end
			CMD_START: begin
				if (!running_q) begin
					running_n = 1'b1;
					latched_n = cfg.prescaler;
					phase_n = '0;
				end
			end
			CMD_STOP: running_n = 1'b0;
			CMD_CLEAR: begin
				count_n = '0;
				phase_n = '0;
				latched_n = cfg.prescaler;
			end
			CMD_TRIGOVF: begin
				count_n = OvfLoad;
				phase_n = '0;
				latched_n = cfg.prescaler;
			end
			CMD_CAPTURE: begin
				for (int i = 0; i < NUM_COMPARE; i++) begin
					if (evt_bit[i]) begin
						cc_n[i] = count_q;
					end
				end
			end
			CMD_WRCC: begin
				for (int i = 0; i < NUM_COMPARE; i++) begin
					if (evt_bit[i]) begin
						cc_n[i] = COUNT_BITS'(wdata_s1);
					end
				end
			end
			CMD_INTENSET: int_en_n = int_en_q | (wdata_s1[EVT_W-1:0] & EnMask);
			CMD_INTENCLR: int_en_n = int_en_q & ~wdata_s1[EVT_W-1:0] & EnMask;
			CMD_EVTENSET: evt_en_n = evt_en_q | (wdata_s1[EVT_W-1:0] & EnMask);
			CMD_EVTENCLR: evt_en_n = evt_en_q & ~wdata_s1[EVT_W-1:0] & EnMask;
			CMD_WREVENT: begin
				if (wdata_s1[0]) begin
					flags_n = flags_q | evt_bit;
				end else begin
					flags_n = flags_q & ~evt_bit;
				end
			end
			CMD_RDCOUNT: rd = RDATA_W'(count_q);
			CMD_RDCC: begin
				for (int i = 0; i < NUM_COMPARE; i++) begin
					if (evt_bit[i]) begin
						rd = RDATA_W'(cc_q[i]);
					end
				end
			end
			default: ;
		endcase
		flags_n = flags_n & EnMask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= '0;
			latched_q <= '0;
			running_q <= 1'b0;
			for (int i = 0; i < NUM_COMPARE; i++) begin
				cc_q[i] <= '0;
			end
			int_en_q <= '0;
			evt_en_q <= '0;
			flags_q <= '0;
		end else if (advance) begin
			count_q <= count_n;
			phase_q <= phase_n;
			latched_q <= latched_n;
			running_q <= running_n;
			cc_q <= cc_n;
			int_en_q <= int_en_n;
			evt_en_q <= evt_en_n;
			flags_q <= flags_n;
		end
	end

	assign res.read_data = rd;
	assign res.compare_events = flags_n[MAX_COMPARE-1:0];
	assign res.overflow_event = flags_n[OVF_IDX];
	assign res.compare_pulse = pulses[MAX_COMPARE-1:0];
	assign res.overflow_pulse = pulses[OVF_IDX];
	assign res.irq = |(flags_n & int_en_n);
	assign res.is_running = running_n;

endmodule

`default_nettype wire

/* hdl/rtc_out.sv */
`default_nettype none

module rtc_out (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   res_valid,
	output logic                  res_ready,
	input  rtc_pkg::rtc_result_t  res,
	output logic                  out_valid,
	input  wire                   out_ready,
	output rtc_pkg::rtc_result_t  out_res
);
	import rtc_pkg::*;

	logic        valid_q;
	rtc_result_t data_q;

	assign res_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

endmodule

`default_nettype wire

/* hdl/rtc_counter_compare_peripheral.sv */
`default_nettype none

// Real-time counter with a 12-bit prescaler, up to four compare channels and an
// overflow event. Each slave-side word carries one command (a clock tick or a register
// access) and produces exactly one master-side word holding read data, latched event
// flags, event pulses, the interrupt level and the run state. One word is accepted per
// clock unless m_tready back-pressure stalls the pipeline; each word passes through the
// core's input register and then the output register before its result appears on the
// master side. The counter, prescaler and event state are updated once per word, as it
// leaves the input register. The prescaler and compare-clear short registers sit on
// the APB port, with the prescaler at address 0 and the short mask at address 4.
module rtc_counter_compare_peripheral #(
	parameter int NUM_COMPARE = rtc_pkg::NUM_COMPARE_DEF,
	parameter int COUNT_BITS = rtc_pkg::COUNT_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// index[2:0], wdata[26:3], zero[31:27]
	input  wire  [rtc_pkg::S_DATA_W-1:0]     s_tdata,
	// cmd[3:0]
	input  wire  [rtc_pkg::S_USER_W-1:0]     s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// read_data[23:0], compare_events[27:24], overflow_event[28], compare_pulse[32:29],
	// overflow_pulse[33], irq[34], is_running[35], zero[39:36]
	output logic [rtc_pkg::M_DATA_W-1:0]     m_tdata,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [rtc_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire  [rtc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [rtc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import rtc_pkg::*;

	rtc_cfg_t    cfg;
	logic        res_valid;
	logic        res_ready;
	rtc_result_t res;
	rtc_result_t out_res;

	rtc_apb_cfg u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rtc_core #(
		.NUM_COMPARE (NUM_COMPARE),
		.COUNT_BITS  (COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser[CMD_W-1:0]),
		.in_index  (s_tdata[IDX_W-1:0]),
		.in_wdata  (s_tdata[IDX_W+WDATA_W-1:IDX_W]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	rtc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = M_DATA_W'(out_res);

endmodule

`default_nettype wire
